// File: design/htd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman tree decoder package
// Shared widths, codes, node entry layout and queue item type.
// ----------------------------------------------------------------------------
package htd_pkg;

  // Store geometry.
  localparam int NODE_COUNT  = 512;
  localparam int SYMBOL_BITS = 8;
  localparam int ADDR_W      = $clog2(NODE_COUNT);

  // Field widths of the ports.
  localparam int FIELD_W   = 9;
  localparam int OUT_SYM_W = 8;
  localparam int IN_SYM_W  = 8;

  localparam int ENTRY_W = 1 + SYMBOL_BITS + 2 * FIELD_W;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Operation codes of an input item.
  localparam logic [1:0] OP_WRITE_NODE   = 2'd0;
  localparam logic [1:0] OP_DECODE_BIT   = 2'd1;
  localparam logic [1:0] OP_CLOSE_STREAM = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] ST_SYMBOL  = 2'd0;
  localparam logic [1:0] ST_CLEAN   = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_DECODE,
    KIND_CLOSE
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROOT_RD,
    BK_STEP_RD
  } back_state_t;

  typedef struct packed {
    logic                   leaf;
    logic [SYMBOL_BITS-1:0] symbol;
    logic [FIELD_W-1:0]     left;
    logic [FIELD_W-1:0]     right;
  } entry_t;

  typedef struct packed {
    kind_t              kind;
    logic               wr_ok;
    logic [FIELD_W-1:0] index;
    entry_t             entry;
    logic               code_bit;
  } cmd_t;

  function automatic logic idx_in_range(logic [FIELD_W-1:0] idx);
    return 32'(idx) < NODE_COUNT;
  endfunction

endpackage
`default_nettype wire

// File: design/huffman_tree_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman tree decoder
// Bit-serial walk over a code tree held in an on-chip node store.
// ----------------------------------------------------------------------------
// In the back end a decode-bit item issues one registered read of the node
// store to fetch the child that the bit selects, and the next cycle looks at
// that entry to decide between emitting a symbol and stepping on.
// The children of the current node and of the root are kept in registers, so
// one store read per bit is all that is needed. The first decode-bit item at
// the root after reset or after a root_node write first fetches the root entry
// in the BK_ROOT_RD state; a write-node item to the root entry or to the entry
// the walk currently stands on refreshes that copy directly. Write-node and
// close-stream items need no store read. A four-item queue sits between the
// input and the back end, and the result sits in an output register, so input
// items keep flowing while a result waits to be taken. The node store needs no
// clearing after reset: entries must be written before the walk reaches them.
// The user must write the root_node register through the cfg port only while
// the block is idle; the block itself does not enforce this. cfg_ready is
// always high.
// ----------------------------------------------------------------------------
module huffman_tree_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [htd_pkg::FIELD_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    operation,
  input  wire logic [htd_pkg::FIELD_W-1:0]   node_index,
  input  wire logic                          node_is_leaf,
  input  wire logic [htd_pkg::IN_SYM_W-1:0]  node_symbol,
  input  wire logic [htd_pkg::FIELD_W-1:0]   left_child,
  input  wire logic [htd_pkg::FIELD_W-1:0]   right_child,
  input  wire logic                          code_bit,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [htd_pkg::OUT_SYM_W-1:0]      decoded_symbol,
  output logic [1:0]                         status
);

  logic          head_valid;
  htd_pkg::cmd_t head;
  logic          pop;

  // The register write is always accepted.
  assign cfg_ready = 1'b1;

  // Front end: accepts and classifies items and holds them in the queue.
  htd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .node_index   (node_index),
    .node_is_leaf (node_is_leaf),
    .node_symbol  (node_symbol),
    .left_child   (left_child),
    .right_child  (right_child),
    .code_bit     (code_bit),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop)
  );

  // Back end: node store, tree walk and result register.
  htd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .decoded_symbol (decoded_symbol),
    .status         (status)
  );

endmodule
`default_nettype wire

// File: design/htd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Read data holds until the next read.
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/htd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman tree decoder front end
// Accepts input items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module htd_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   operation,
  input  wire logic [htd_pkg::FIELD_W-1:0]  node_index,
  input  wire logic                         node_is_leaf,
  input  wire logic [htd_pkg::IN_SYM_W-1:0] node_symbol,
  input  wire logic [htd_pkg::FIELD_W-1:0]  left_child,
  input  wire logic [htd_pkg::FIELD_W-1:0]  right_child,
  input  wire logic                         code_bit,
  output logic                              head_valid,
  output htd_pkg::cmd_t                     head,
  input  wire logic                         pop
);

  htd_pkg::cmd_t                 q [htd_pkg::QUEUE_DEPTH];
  logic [htd_pkg::QPTR_W-1:0]    wptr;
  logic [htd_pkg::QPTR_W-1:0]    rptr;
  logic [htd_pkg::QPTR_W:0]      count;
  htd_pkg::cmd_t                 cmd;
  logic                          keep;
  logic                          push;

  // Classify the incoming item; unused operation codes are dropped here.
  always_comb begin
    cmd.kind     = htd_pkg::KIND_WRITE;
    cmd.wr_ok    = htd_pkg::idx_in_range(node_index);
    cmd.index    = node_index;
    cmd.entry.leaf   = node_is_leaf;
    cmd.entry.symbol = htd_pkg::SYMBOL_BITS'(node_symbol);
    cmd.entry.left   = left_child;
    cmd.entry.right  = right_child;
    cmd.code_bit = code_bit;
    keep         = 1'b1;
    unique case (operation)
      htd_pkg::OP_WRITE_NODE:   cmd.kind = htd_pkg::KIND_WRITE;
      htd_pkg::OP_DECODE_BIT:   cmd.kind = htd_pkg::KIND_DECODE;
      htd_pkg::OP_CLOSE_STREAM: cmd.kind = htd_pkg::KIND_CLOSE;
      default:                  keep     = 1'b0;
    endcase
  end

  assign in_ready   = count != (htd_pkg::QPTR_W + 1)'(htd_pkg::QUEUE_DEPTH);
  assign push       = in_valid && in_ready && keep;
  assign head_valid = count != '0;
  assign head       = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == htd_pkg::QPTR_W'(htd_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == htd_pkg::QPTR_W'(htd_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/htd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman tree decoder back end
// Executes queued items against the node store and drives the result register.
// ----------------------------------------------------------------------------
module htd_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic [htd_pkg::FIELD_W-1:0]   cfg_data,
  input  wire logic                          head_valid,
  input  wire htd_pkg::cmd_t                 head,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [htd_pkg::OUT_SYM_W-1:0]      decoded_symbol,
  output logic [1:0]                         status
);

  htd_pkg::back_state_t          state;
  htd_pkg::back_state_t          state_next;

  logic [htd_pkg::FIELD_W-1:0]   root_node;
  logic                          root_stale;
  logic [htd_pkg::FIELD_W-1:0]   root_left;
  logic [htd_pkg::FIELD_W-1:0]   root_right;
  logic [htd_pkg::FIELD_W-1:0]   walk_idx;
  logic [htd_pkg::FIELD_W-1:0]   cur_left;
  logic [htd_pkg::FIELD_W-1:0]   cur_right;
  logic                          mid_code;
  logic                          rd_oor;

  logic                          slot_free;
  logic [htd_pkg::FIELD_W-1:0]   step_idx;
  logic [htd_pkg::FIELD_W-1:0]   rd_idx;
  logic                          ram_we;
  logic                          ram_re;
  logic [htd_pkg::ENTRY_W-1:0]   ram_rdata;
  htd_pkg::entry_t               rd_entry;
  logic                          load_out;
  logic [htd_pkg::OUT_SYM_W-1:0] out_sym_next;
  logic [1:0]                    out_status_next;
  logic                          root_hit;
  logic                          cur_hit;

  htd_ram #(
    .WIDTH (htd_pkg::ENTRY_W),
    .DEPTH (htd_pkg::NODE_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (htd_pkg::ADDR_W'(head.index)),
    .wdata (head.entry),
    .re    (ram_re),
    .raddr (htd_pkg::ADDR_W'(rd_idx)),
    .rdata (ram_rdata)
  );

  assign slot_free = !out_valid || out_ready;
  // An index beyond the store reads as an all-zero internal node.
  assign rd_entry  = rd_oor ? '0 : htd_pkg::entry_t'(ram_rdata);
  assign root_hit  = head.wr_ok && (head.index == root_node);
  assign cur_hit   = head.wr_ok && (head.index == walk_idx);

  always_comb begin
    if (head.code_bit) begin
      step_idx = mid_code ? cur_right : root_right;
    end else begin
      step_idx = mid_code ? cur_left : root_left;
    end
  end

  always_comb begin
    state_next      = state;
    pop             = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    rd_idx          = step_idx;
    load_out        = 1'b0;
    out_sym_next    = '0;
    out_status_next = htd_pkg::ST_SYMBOL;
    unique case (state)
      htd_pkg::BK_IDLE: begin
        if (head_valid) begin
          unique case (head.kind)
            htd_pkg::KIND_WRITE: begin
              pop    = 1'b1;
              ram_we = head.wr_ok;
            end
            htd_pkg::KIND_CLOSE: begin
              if (slot_free) begin
                pop             = 1'b1;
                load_out        = 1'b1;
                out_status_next = mid_code ? htd_pkg::ST_DROPPED : htd_pkg::ST_CLEAN;
              end
            end
            htd_pkg::KIND_DECODE: begin
              ram_re = 1'b1;
              if (!mid_code && root_stale) begin
                // Root children are not cached yet: fetch the root first.
                rd_idx     = root_node;
                state_next = htd_pkg::BK_ROOT_RD;
              end else begin
                pop        = 1'b1;
                state_next = htd_pkg::BK_STEP_RD;
              end
            end
            default: ;
          endcase
        end
      end
      htd_pkg::BK_ROOT_RD: begin
        state_next = htd_pkg::BK_IDLE;
      end
      htd_pkg::BK_STEP_RD: begin
        if (!rd_entry.leaf) begin
          state_next = htd_pkg::BK_IDLE;
        end else if (slot_free) begin
          load_out     = 1'b1;
          out_sym_next = htd_pkg::OUT_SYM_W'(rd_entry.symbol);
          state_next   = htd_pkg::BK_IDLE;
        end
      end
      default: state_next = htd_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htd_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_node  <= '0;
      root_stale <= 1'b1;
      mid_code   <= 1'b0;
      walk_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        root_node  <= cfg_data;
        root_stale <= 1'b1;
      end else if (state == htd_pkg::BK_ROOT_RD) begin
        root_stale <= 1'b0;
      end else if (ram_we && root_hit) begin
        root_stale <= 1'b0;
      end

      // The entry a bit steps to; it becomes the walk position if internal.
      if (pop && head.kind == htd_pkg::KIND_DECODE) begin
        walk_idx <= step_idx;
      end

      if (pop && head.kind == htd_pkg::KIND_CLOSE) begin
        mid_code <= 1'b0;
      end else if (state == htd_pkg::BK_STEP_RD) begin
        if (!rd_entry.leaf) begin
          mid_code <= 1'b1;
        end else if (load_out) begin
          mid_code <= 1'b0;
        end
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_oor <= !htd_pkg::idx_in_range(rd_idx);
    end
    if (state == htd_pkg::BK_ROOT_RD) begin
      root_left  <= rd_entry.left;
      root_right <= rd_entry.right;
    end else if (ram_we && root_hit) begin
      root_left  <= head.entry.left;
      root_right <= head.entry.right;
    end
    if (state == htd_pkg::BK_STEP_RD && !rd_entry.leaf) begin
      cur_left  <= rd_entry.left;
      cur_right <= rd_entry.right;
    end else if (ram_we && cur_hit) begin
      // A write to the node the walk stands on steers the next bit.
      cur_left  <= head.entry.left;
      cur_right <= head.entry.right;
    end
    if (load_out) begin
      decoded_symbol <= out_sym_next;
      status         <= out_status_next;
    end
  end

endmodule
`default_nettype wire

// File: design/htd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman tree decoder checker
// Port-level properties of the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module htd_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [htd_pkg::OUT_SYM_W-1:0] decoded_symbol,
  input wire logic [1:0]                    status
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(decoded_symbol) && $stable(status))
    else $error("result changed while stalled");

  // Close reports carry a zero symbol.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != htd_pkg::ST_SYMBOL |-> decoded_symbol == '0)
    else $error("close report with nonzero symbol");

  // No result is shown in the cycle after reset.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (.*);
`default_nettype wire
